// ===== hdl/assert_macros.svh =====
// assertion macros shared by the parser rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/brlp_pkg.sv =====
// types and constants of the bus response line parser
// no dependencies
package brlp_pkg;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_R_UP  = 8'h52;
    localparam logic [7:0] CH_R_LO  = 8'h72;
    localparam logic [7:0] CH_W_UP  = 8'h57;
    localparam logic [7:0] CH_W_LO  = 8'h77;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_I_LO  = 8'h69;
    localparam logic [7:0] CH_U_LO  = 8'h75;

    // parse phases
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_ARG0  = 2'd1;
    localparam logic [1:0] PH_ARG1  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    // verdict codes
    localparam logic [2:0] V_OK    = 3'd0;
    localparam logic [2:0] V_UNREC = 3'd1;
    localparam logic [2:0] V_UNEXP = 3'd2;
    localparam logic [2:0] V_INV   = 3'd3;
    localparam logic [2:0] V_INTR  = 3'd4;
    localparam logic [2:0] V_ERR   = 3'd5;

    // ack kinds
    localparam logic [1:0] ACK_PLAIN = 2'd0;
    localparam logic [1:0] ACK_YES   = 2'd1;
    localparam logic [1:0] ACK_NO    = 2'd2;

    // line summary handed to the verdict logic
    typedef struct packed {
        logic [7:0] code;
        logic [1:0] args;
        logic       syntax_bad;
        logic       pending;
        logic [7:0] cmd;
    } line_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic [1:0] ack_kind;
    } result_t;

endpackage

// ===== hdl/brlp_if.sv =====
// valid/ready channels of the bus response line parser
// depends on nothing but the handshake convention
interface brlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       request_pending;
    logic [7:0] pending_cmd;

    modport source (output valid, output rx_byte, output request_pending,
                    output pending_cmd, input ready);
    modport sink (input valid, input rx_byte, input request_pending,
                  input pending_cmd, output ready);
endinterface

interface brlp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [1:0]  ack_kind;
    logic [1:0]  arg_count;
    logic [15:0] first_value;
    logic [15:0] second_value;
    logic [7:0]  response_code;

    modport source (output valid, output verdict, output ack_kind, output arg_count,
                    output first_value, output second_value, output response_code,
                    input ready);
    modport sink (input valid, input verdict, input ack_kind, input arg_count,
                  input first_value, input second_value, input response_code,
                  output ready);
endinterface

// ===== hdl/brlp_verdict.sv =====
// response code table and verdict selection for one finished line
// depends on brlp_pkg
module brlp_verdict
(
    input  brlp_pkg::line_t   line,
    output brlp_pkg::result_t result
);

    logic [2:0] base;
    logic [2:0] verdict;
    logic [1:0] ack;
    logic [7:0] exp_cmd;
    logic [1:0] need_args;

    always_comb
    begin
        base      = line.syntax_bad ? brlp_pkg::V_INV : brlp_pkg::V_OK;
        ack       = brlp_pkg::ACK_PLAIN;
        exp_cmd   = brlp_pkg::CH_NUL;
        need_args = 2'd0;
        case (line.code)
            brlp_pkg::CH_R_UP:
            begin
                exp_cmd   = brlp_pkg::CH_R_UP;
                need_args = 2'd1;
                ack       = brlp_pkg::ACK_YES;
            end
            brlp_pkg::CH_R_LO:
            begin
                exp_cmd   = brlp_pkg::CH_R_UP;
                need_args = 2'd1;
                ack       = brlp_pkg::ACK_NO;
            end
            brlp_pkg::CH_W_UP:
            begin
                exp_cmd = brlp_pkg::CH_W_UP;
                ack     = brlp_pkg::ACK_YES;
            end
            brlp_pkg::CH_W_LO:
            begin
                exp_cmd = brlp_pkg::CH_W_UP;
                ack     = brlp_pkg::ACK_NO;
            end
            brlp_pkg::CH_V:
            begin
                exp_cmd   = brlp_pkg::CH_V;
                need_args = 2'd3;
            end
            // interrupt and error ignore syntax, only the count matters
            brlp_pkg::CH_I:
            begin
                base      = brlp_pkg::V_INTR;
                need_args = 2'd1;
            end
            brlp_pkg::CH_E:
            begin
                base      = brlp_pkg::V_ERR;
                need_args = 2'd1;
            end
            brlp_pkg::CH_A, brlp_pkg::CH_B, brlp_pkg::CH_S, brlp_pkg::CH_C,
            brlp_pkg::CH_F_UP:
            begin
                exp_cmd = line.code;
            end
            brlp_pkg::CH_ZERO:
            begin
                exp_cmd = brlp_pkg::CH_NL;
            end
            brlp_pkg::CH_D, brlp_pkg::CH_F_LO, brlp_pkg::CH_I_LO, brlp_pkg::CH_U_LO:
            begin
                exp_cmd   = line.code;
                need_args = 2'd1;
            end
            default:
            begin
                base = brlp_pkg::V_UNREC;
            end
        endcase

        verdict = base;
        if (base == brlp_pkg::V_OK && (!line.pending || line.cmd != exp_cmd))
        begin
            verdict = brlp_pkg::V_UNEXP;
        end
        else if ((base == brlp_pkg::V_OK || base == brlp_pkg::V_INTR ||
                  base == brlp_pkg::V_ERR) && line.args != need_args)
        begin
            verdict = brlp_pkg::V_INV;
        end

        result.verdict  = verdict;
        result.ack_kind = (verdict == brlp_pkg::V_OK) ? ack : brlp_pkg::ACK_PLAIN;
    end

endmodule

// ===== hdl/bus_response_line_parser.sv =====
// bus response line parser: one response byte per cycle, one verdict word per line
// latency: the verdict word is valid in the cycle after the newline is accepted
// throughput: one byte per cycle, except that a newline stalls while a verdict word waits unaccepted
// a new byte is taken while a verdict waits, unless a newline would overwrite it
// reset clears the line state and empties the result register
// depends on brlp_pkg, brlp_if, brlp_verdict and assert_macros.svh
`include "assert_macros.svh"

module bus_response_line_parser
(
    input  logic              clk,
    input  logic              rst_n,
    brlp_in_if.sink           in_ch,
    brlp_out_if.source        out_ch
);

    logic [1:0]  phase_reg,  phase_next;
    logic [7:0]  code_reg,   code_next;
    logic [15:0] first_reg,  first_next;
    logic [15:0] second_reg, second_next;
    logic [1:0]  args_reg,   args_next;
    logic        bad_reg,    bad_next;
    logic        seen_reg,   seen_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  verdict_reg;
    logic [1:0]  ack_reg;
    logic [1:0]  count_reg;
    logic [15:0] val1_reg;
    logic [15:0] val2_reg;
    logic [7:0]  rcode_reg;

    logic        in_fire;
    logic        is_nl;
    logic        is_hex;
    logic [3:0]  digit;
    logic [1:0]  end_args;
    logic        end_bad;
    brlp_pkg::line_t   line;
    brlp_pkg::result_t result;

    // only a newline needs the result register free
    assign in_ch.ready = !out_valid_reg || out_ch.ready || !is_nl;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign is_nl       = in_ch.rx_byte == brlp_pkg::CH_NL;

    // hex digit decode
    always_comb
    begin
        is_hex = 1'b1;
        digit  = 4'd0;
        if (in_ch.rx_byte >= 8'h30 && in_ch.rx_byte <= 8'h39)
            digit = 4'(in_ch.rx_byte - 8'h30);
        else if (in_ch.rx_byte >= 8'h61 && in_ch.rx_byte <= 8'h66)
            digit = 4'(in_ch.rx_byte - 8'h57);
        else if (in_ch.rx_byte >= 8'h41 && in_ch.rx_byte <= 8'h46)
            digit = 4'(in_ch.rx_byte - 8'h37);
        else
            is_hex = 1'b0;
    end

    // count and syntax once the text ends in the current phase
    always_comb
    begin
        end_args = args_reg;
        end_bad  = bad_reg;
        if (phase_reg == brlp_pkg::PH_ARG0 && seen_reg)
            end_args = 2'd1;
        if (phase_reg == brlp_pkg::PH_ARG1)
        begin
            end_bad = 1'b1;
            if (seen_reg)
                end_args = 2'd2;
        end
    end

    always_comb
    begin
        line.code       = code_reg;
        line.args       = end_args;
        line.syntax_bad = end_bad;
        line.pending    = in_ch.request_pending;
        line.cmd        = in_ch.pending_cmd;
    end

    brlp_verdict u_verdict
    (
        .line   (line),
        .result (result)
    );

    // line state update
    always_comb
    begin
        phase_next  = phase_reg;
        code_next   = code_reg;
        first_next  = first_reg;
        second_next = second_reg;
        args_next   = args_reg;
        bad_next    = bad_reg;
        seen_next   = seen_reg;
        if (in_fire)
        begin
            if (is_nl)
            begin
                phase_next  = brlp_pkg::PH_START;
                code_next   = 8'd0;
                first_next  = 16'd0;
                second_next = 16'd0;
                args_next   = 2'd0;
                bad_next    = 1'b0;
                seen_next   = 1'b0;
            end
            else if (phase_reg == brlp_pkg::PH_DONE)
            begin
                // rest of line ignored
            end
            else if (in_ch.rx_byte == brlp_pkg::CH_NUL)
            begin
                args_next  = end_args;
                bad_next   = end_bad;
                phase_next = brlp_pkg::PH_DONE;
            end
            else if (phase_reg == brlp_pkg::PH_START)
            begin
                code_next  = in_ch.rx_byte;
                phase_next = brlp_pkg::PH_ARG0;
            end
            else if (is_hex)
            begin
                seen_next = 1'b1;
                if (phase_reg == brlp_pkg::PH_ARG0)
                    first_next = {first_reg[11:0], digit};
                else
                    second_next = {second_reg[11:0], digit};
            end
            else if (!seen_reg)
            begin
                bad_next   = 1'b1;
                phase_next = brlp_pkg::PH_DONE;
            end
            else if (phase_reg == brlp_pkg::PH_ARG0)
            begin
                args_next = 2'd1;
                if (in_ch.rx_byte == brlp_pkg::CH_COLON)
                begin
                    phase_next = brlp_pkg::PH_ARG1;
                    seen_next  = 1'b0;
                end
                else
                begin
                    bad_next   = 1'b1;
                    phase_next = brlp_pkg::PH_DONE;
                end
            end
            else
            begin
                // colon after the second value means a name follows
                if (in_ch.rx_byte == brlp_pkg::CH_COLON)
                    args_next = 2'd3;
                else
                begin
                    args_next = 2'd2;
                    bad_next  = 1'b1;
                end
                phase_next = brlp_pkg::PH_DONE;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire && is_nl)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= brlp_pkg::PH_START;
            code_reg      <= 8'd0;
            first_reg     <= 16'd0;
            second_reg    <= 16'd0;
            args_reg      <= 2'd0;
            bad_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            code_reg      <= code_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            args_reg      <= args_next;
            bad_reg       <= bad_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && is_nl)
        begin
            verdict_reg <= result.verdict;
            ack_reg     <= result.ack_kind;
            count_reg   <= end_args;
            val1_reg    <= first_reg;
            val2_reg    <= second_reg;
            rcode_reg   <= code_reg;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.verdict       = verdict_reg;
    assign out_ch.ack_kind      = ack_reg;
    assign out_ch.arg_count     = count_reg;
    assign out_ch.first_value   = val1_reg;
    assign out_ch.second_value  = val2_reg;
    assign out_ch.response_code = rcode_reg;

    `ASSERT_NEXT(a_nl_gives_word, clk, rst_n, in_fire && is_nl, out_valid_reg,
        "newline accepted without a verdict word")
    `ASSERT_NEXT(a_nl_clears_line, clk, rst_n, in_fire && is_nl,
        phase_reg == brlp_pkg::PH_START && args_reg == 2'd0 && !bad_reg,
        "line state not cleared after newline")
    `ASSERT_IMPLY(a_start_empty, clk, rst_n, phase_reg == brlp_pkg::PH_START,
        code_reg == 8'd0 && first_reg == 16'd0 && !seen_reg,
        "line state not empty at start of line")
    `ASSERT_IMPLY(a_ack_only_ok, clk, rst_n,
        out_valid_reg && verdict_reg != brlp_pkg::V_OK,
        ack_reg == brlp_pkg::ACK_PLAIN, "ack kind given on a failed verdict")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for bus_response_line_parser: a directed table of lines, then random lines
// every verdict word is checked against the table's expected word or, for random lines, a line predictor
// kept in step with the accepted bytes; depends on brlp_pkg, brlp_if and the parser rtl
module tb;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [1:0]  ack_kind;
        logic [1:0]  arg_count;
        logic [15:0] first_value;
        logic [15:0] second_value;
        logic [7:0]  response_code;
    } verdict_word_t;

    typedef struct packed {
        logic [7:0]    rx;
        logic          pend;
        logic [7:0]    cmd;
        logic          typed;
        verdict_word_t want;
    } line_row_t;

    localparam int RANDOM_BYTES = 450;
    localparam int CALM_AFTER = 380;
    localparam int CYCLE_LIMIT = 200000;
    localparam verdict_word_t NO_WORD = '0;

    logic clk;
    logic rst_n;

    brlp_in_if  in_ch();
    brlp_out_if out_ch();

    bus_response_line_parser uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // mirror of the line state
    logic [1:0]  ln_phase = brlp_pkg::PH_START;
    logic [7:0]  ln_code = 8'h00;
    logic [15:0] ln_first = 16'h0000;
    logic [15:0] ln_second = 16'h0000;
    logic [1:0]  ln_args = 2'd0;
    logic        ln_bad = 1'b0;
    logic        ln_digit = 1'b0;

    verdict_word_t verdict_q[$];
    line_row_t     dir_rows[$];

    logic [7:0] known_codes [17] = '{brlp_pkg::CH_R_UP, brlp_pkg::CH_R_LO,
                                     brlp_pkg::CH_W_UP, brlp_pkg::CH_W_LO,
                                     brlp_pkg::CH_V, brlp_pkg::CH_I, brlp_pkg::CH_E,
                                     brlp_pkg::CH_A, brlp_pkg::CH_B, brlp_pkg::CH_S,
                                     brlp_pkg::CH_C, brlp_pkg::CH_F_UP,
                                     brlp_pkg::CH_ZERO, brlp_pkg::CH_D,
                                     brlp_pkg::CH_F_LO, brlp_pkg::CH_I_LO,
                                     brlp_pkg::CH_U_LO};

    int            fail_count = 0;
    int            cycle_count = 0;
    int            bytes_sent = 0;
    int            stall_left = 0;
    bit            calm = 1'b0;
    logic          cur_typed = 1'b0;
    verdict_word_t cur_want = '0;
    bit            got_word;
    verdict_word_t next_word;
    verdict_word_t want_word;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= brlp_pkg::CH_ZERO && c <= "9")
            return 5'(c - brlp_pkg::CH_ZERO);
        if (c >= "a" && c <= "f")
            return 5'(c - "a" + 8'd10);
        if (c >= "A" && c <= "F")
            return 5'(c - "A" + 8'd10);
        return 5'd16;
    endfunction

    // zero byte or newline reached inside the current phase
    task automatic close_text();
        if (ln_phase == brlp_pkg::PH_ARG0)
        begin
            if (ln_digit)
                ln_args = 2'd1;
        end
        else if (ln_phase == brlp_pkg::PH_ARG1)
        begin
            if (ln_digit)
                ln_args = 2'd2;
            ln_bad = 1'b1;
        end
        ln_phase = brlp_pkg::PH_DONE;
    endtask

    task automatic parse_byte(input logic [7:0] c, input logic pend, input logic [7:0] cmd,
                              output bit got, output verdict_word_t w);
        logic [4:0] d;
        logic [2:0] verdict;
        logic [1:0] ack;
        logic [7:0] want_cmd;
        logic [1:0] want_args;
        got = 1'b0;
        w = '0;
        if (c != brlp_pkg::CH_NL)
        begin
            if (ln_phase == brlp_pkg::PH_DONE)
                return;
            if (c == brlp_pkg::CH_NUL)
            begin
                close_text();
                return;
            end
            if (ln_phase == brlp_pkg::PH_START)
            begin
                ln_code = c;
                ln_phase = brlp_pkg::PH_ARG0;
                return;
            end
            d = hex_digit(c);
            if (d < 5'd16)
            begin
                ln_digit = 1'b1;
                if (ln_phase == brlp_pkg::PH_ARG0)
                    ln_first = {ln_first[11:0], d[3:0]};
                else
                    ln_second = {ln_second[11:0], d[3:0]};
            end
            else if (!ln_digit)
            begin
                ln_bad = 1'b1;
                ln_phase = brlp_pkg::PH_DONE;
            end
            else if (ln_phase == brlp_pkg::PH_ARG0)
            begin
                ln_args = 2'd1;
                if (c == brlp_pkg::CH_COLON)
                begin
                    ln_phase = brlp_pkg::PH_ARG1;
                    ln_digit = 1'b0;
                end
                else
                begin
                    ln_bad = 1'b1;
                    ln_phase = brlp_pkg::PH_DONE;
                end
            end
            else
            begin
                // a colon after the second value means a name follows
                ln_args = (c == brlp_pkg::CH_COLON) ? 2'd3 : 2'd2;
                if (c != brlp_pkg::CH_COLON)
                    ln_bad = 1'b1;
                ln_phase = brlp_pkg::PH_DONE;
            end
            return;
        end

        close_text();
        verdict = ln_bad ? brlp_pkg::V_INV : brlp_pkg::V_OK;
        ack = brlp_pkg::ACK_PLAIN;
        want_cmd = brlp_pkg::CH_NUL;
        want_args = 2'd0;
        case (ln_code)
            brlp_pkg::CH_R_UP, brlp_pkg::CH_R_LO:
            begin
                want_cmd = brlp_pkg::CH_R_UP;
                want_args = 2'd1;
                ack = (ln_code == brlp_pkg::CH_R_UP) ? brlp_pkg::ACK_YES : brlp_pkg::ACK_NO;
            end
            brlp_pkg::CH_W_UP, brlp_pkg::CH_W_LO:
            begin
                want_cmd = brlp_pkg::CH_W_UP;
                ack = (ln_code == brlp_pkg::CH_W_UP) ? brlp_pkg::ACK_YES : brlp_pkg::ACK_NO;
            end
            brlp_pkg::CH_V:
            begin
                want_cmd = brlp_pkg::CH_V;
                want_args = 2'd3;
            end
            brlp_pkg::CH_I:
            begin
                verdict = brlp_pkg::V_INTR;
                want_args = 2'd1;
            end
            brlp_pkg::CH_E:
            begin
                verdict = brlp_pkg::V_ERR;
                want_args = 2'd1;
            end
            brlp_pkg::CH_A, brlp_pkg::CH_B, brlp_pkg::CH_S, brlp_pkg::CH_C,
            brlp_pkg::CH_F_UP:
                want_cmd = ln_code;
            brlp_pkg::CH_D, brlp_pkg::CH_F_LO, brlp_pkg::CH_I_LO, brlp_pkg::CH_U_LO:
            begin
                want_cmd = ln_code;
                want_args = 2'd1;
            end
            brlp_pkg::CH_ZERO:
                want_cmd = brlp_pkg::CH_NL;
            default:
                verdict = brlp_pkg::V_UNREC;
        endcase
        // interrupt and error lines ignore syntax, only the count decides
        if (verdict == brlp_pkg::V_OK && (!pend || cmd != want_cmd))
            verdict = brlp_pkg::V_UNEXP;
        else if ((verdict == brlp_pkg::V_OK || verdict == brlp_pkg::V_INTR ||
                  verdict == brlp_pkg::V_ERR) && ln_args != want_args)
            verdict = brlp_pkg::V_INV;
        if (verdict != brlp_pkg::V_OK)
            ack = brlp_pkg::ACK_PLAIN;
        w = {verdict, ack, ln_args, ln_first, ln_second, ln_code};
        got = 1'b1;

        ln_phase = brlp_pkg::PH_START;
        ln_code = 8'h00;
        ln_first = 16'h0000;
        ln_second = 16'h0000;
        ln_args = 2'd0;
        ln_bad = 1'b0;
        ln_digit = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] seen);
        if (want !== seen)
        begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            fail_count++;
        end
    endtask

    function automatic logic [7:0] any_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == brlp_pkg::CH_NL)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic void push_hex(ref logic [7:0] q[$]);
        int ndig;
        int d;
        ndig = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        repeat (ndig)
        begin
            d = $urandom_range(0, 15);
            if (d < 10)
                q.push_back(8'(brlp_pkg::CH_ZERO + d));
            else
                q.push_back(8'(($urandom_range(0, 1) ? "a" : "A") + d - 10));
        end
    endfunction

    // drive one byte at the falling edge and hold it until it is taken
    task automatic send_byte(input logic [7:0] b, input logic pend, input logic [7:0] cmd,
                             input logic typed, input verdict_word_t want);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.rx_byte = b;
        in_ch.request_pending = pend;
        in_ch.pending_cmd = cmd;
        cur_typed = typed;
        cur_want = want;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_line();
        logic [7:0] q[$];
        logic [7:0] code;
        logic [7:0] cmd;
        logic       pend;
        int         nargs;
        int         pos;
        if ($urandom_range(0, 9) < 8)
        begin
            pos = $urandom_range(0, 17);
            code = (pos < 17) ? known_codes[pos] : any_byte();
            q.push_back(code);
            nargs = $urandom_range(0, 3);
            if (nargs >= 1)
                push_hex(q);
            if (nargs >= 2)
            begin
                q.push_back(brlp_pkg::CH_COLON);
                push_hex(q);
            end
            if (nargs == 3)
            begin
                q.push_back(brlp_pkg::CH_COLON);
                repeat ($urandom_range(0, 4))
                    q.push_back(8'($urandom_range(8'h20, 8'h7e)));
            end
            // break a line now and then
            if ($urandom_range(0, 7) == 0)
                q.insert($urandom_range(0, q.size()), any_byte());
        end
        else
        begin
            repeat ($urandom_range(0, 8))
            begin
                case ($urandom_range(0, 3))
                    0: q.push_back(brlp_pkg::CH_NUL);
                    1: q.push_back(brlp_pkg::CH_COLON);
                    default: q.push_back(any_byte());
                endcase
            end
            code = (q.size() != 0) ? q[0] : brlp_pkg::CH_NUL;
        end
        q.push_back(brlp_pkg::CH_NL);

        pend = ($urandom_range(0, 3) != 0);
        cmd = (code == brlp_pkg::CH_R_LO) ? brlp_pkg::CH_R_UP :
              (code == brlp_pkg::CH_W_LO) ? brlp_pkg::CH_W_UP :
              (code == brlp_pkg::CH_ZERO) ? brlp_pkg::CH_NL : code;
        if ($urandom_range(0, 3) == 0)
            cmd = 8'($urandom_range(0, 255));

        foreach (q[i])
        begin
            if (i == q.size() - 1)
                send_byte(q[i], pend, cmd, 1'b0, NO_WORD);
            else
                send_byte(q[i], 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'b0, NO_WORD);
        end
        bytes_sent += q.size();
    endtask

    // prediction on every accepted byte, comparison on every accepted verdict word
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            parse_byte(in_ch.rx_byte, in_ch.request_pending, in_ch.pending_cmd,
                       got_word, next_word);
            if (got_word)
                verdict_q.push_back(cur_typed ? cur_want : next_word);
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("verdict word with none expected");
                fail_count++;
            end
            else
            begin
                want_word = verdict_q.pop_front();
                check_field("verdict", 16'(want_word.verdict), 16'(out_ch.verdict));
                check_field("ack_kind", 16'(want_word.ack_kind), 16'(out_ch.ack_kind));
                check_field("arg_count", 16'(want_word.arg_count), 16'(out_ch.arg_count));
                check_field("first_value", want_word.first_value, out_ch.first_value);
                check_field("second_value", want_word.second_value, out_ch.second_value);
                check_field("response_code", 16'(want_word.response_code),
                            16'(out_ch.response_code));
            end
        end
    end

    // receiver stalls in bursts
    always @(negedge clk)
    begin
        if (calm)
            out_ch.ready = 1'b1;
        else if (stall_left != 0)
        begin
            stall_left--;
            if (stall_left == 0)
                out_ch.ready = 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            out_ch.ready = 1'b0;
            stall_left = $urandom_range(1, 14);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        bit paused;
        paused = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.rx_byte = 8'h00;
        in_ch.request_pending = 1'b0;
        in_ch.pending_cmd = 8'h00;
        out_ch.ready = 1'b1;

        // rx, pending, cmd, typed, expected verdict word on the newline
        dir_rows = '{
            {brlp_pkg::CH_NL,   1'b0, brlp_pkg::CH_NUL,  1'b1,
             {brlp_pkg::V_UNREC, brlp_pkg::ACK_PLAIN, 2'd0, 16'h0000, 16'h0000,
              brlp_pkg::CH_NUL}},
            {brlp_pkg::CH_W_UP, 1'b1, brlp_pkg::CH_W_UP, 1'b0, NO_WORD},
            {brlp_pkg::CH_NL,   1'b1, brlp_pkg::CH_W_UP, 1'b1,
             {brlp_pkg::V_OK, brlp_pkg::ACK_YES, 2'd0, 16'h0000, 16'h0000,
              brlp_pkg::CH_W_UP}},
            {brlp_pkg::CH_R_LO, 1'b1, brlp_pkg::CH_R_UP, 1'b0, NO_WORD},
            {"f",               1'b1, brlp_pkg::CH_R_UP, 1'b0, NO_WORD},
            {"F",               1'b0, 8'hFF,             1'b0, NO_WORD},
            {"f",               1'b1, brlp_pkg::CH_R_UP, 1'b0, NO_WORD},
            {"F",               1'b1, brlp_pkg::CH_R_UP, 1'b0, NO_WORD},
            {brlp_pkg::CH_NL,   1'b1, brlp_pkg::CH_R_UP, 1'b1,
             {brlp_pkg::V_OK, brlp_pkg::ACK_NO, 2'd1, 16'hFFFF, 16'h0000,
              brlp_pkg::CH_R_LO}},
            {brlp_pkg::CH_I,    1'b0, brlp_pkg::CH_NUL,  1'b0, NO_WORD},
            {"5",               1'b0, brlp_pkg::CH_NUL,  1'b0, NO_WORD},
            {brlp_pkg::CH_NL,   1'b0, brlp_pkg::CH_NUL,  1'b1,
             {brlp_pkg::V_INTR, brlp_pkg::ACK_PLAIN, 2'd1, 16'h0005, 16'h0000,
              brlp_pkg::CH_I}},
            {brlp_pkg::CH_E,    1'b0, brlp_pkg::CH_NUL,  1'b0, NO_WORD},
            {brlp_pkg::CH_NL,   1'b0, brlp_pkg::CH_NUL,  1'b1,
             {brlp_pkg::V_INV, brlp_pkg::ACK_PLAIN, 2'd0, 16'h0000, 16'h0000,
              brlp_pkg::CH_E}},
            // zero byte stops parsing mid second value
            {brlp_pkg::CH_V,     1'b1, brlp_pkg::CH_V, 1'b0, NO_WORD},
            {"1",                1'b1, brlp_pkg::CH_V, 1'b0, NO_WORD},
            {brlp_pkg::CH_COLON, 1'b1, brlp_pkg::CH_V, 1'b0, NO_WORD},
            {"2",                1'b1, brlp_pkg::CH_V, 1'b0, NO_WORD},
            {brlp_pkg::CH_NUL,   1'b1, brlp_pkg::CH_V, 1'b0, NO_WORD},
            {brlp_pkg::CH_COLON, 1'b1, brlp_pkg::CH_V, 1'b0, NO_WORD},
            {brlp_pkg::CH_NL,    1'b1, brlp_pkg::CH_V, 1'b1,
             {brlp_pkg::V_INV, brlp_pkg::ACK_PLAIN, 2'd2, 16'h0001, 16'h0002,
              brlp_pkg::CH_V}},
            {8'hFF,             1'b1, 8'hFF,             1'b0, NO_WORD},
            {brlp_pkg::CH_NL,   1'b1, 8'hFF,             1'b1,
             {brlp_pkg::V_UNREC, brlp_pkg::ACK_PLAIN, 2'd0, 16'h0000, 16'h0000,
              8'hFF}},
            {brlp_pkg::CH_ZERO, 1'b1, brlp_pkg::CH_NL,   1'b0, NO_WORD},
            {brlp_pkg::CH_NL,   1'b1, brlp_pkg::CH_NL,   1'b1,
             {brlp_pkg::V_OK, brlp_pkg::ACK_PLAIN, 2'd0, 16'h0000, 16'h0000,
              brlp_pkg::CH_ZERO}}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].rx, dir_rows[i].pend, dir_rows[i].cmd,
                      dir_rows[i].typed, dir_rows[i].want);
        in_ch.valid = 1'b0;
        while (verdict_q.size() != 0)
            @(negedge clk);

        while (bytes_sent < RANDOM_BYTES)
        begin
            if (bytes_sent >= CALM_AFTER)
                calm = 1'b1;
            // hold off once until the parser has drained
            if (!paused && bytes_sent >= RANDOM_BYTES / 2)
            begin
                in_ch.valid = 1'b0;
                while (verdict_q.size() != 0)
                    @(negedge clk);
                paused = 1'b1;
            end
            random_line();
        end
        in_ch.valid = 1'b0;

        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/brlp_pkg.sv
hdl/brlp_if.sv
hdl/brlp_verdict.sv
hdl/bus_response_line_parser.sv
tb/sv/tb.sv
